// ===== rtl/cprq_pkg.sv =====
// Shared types, constants and helpers for the coalescing packet ring queue.
package cprq_pkg;

  localparam int DEPTH        = 16;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int LEN_W        = $clog2(DEPTH + 1);
  localparam int QLEN_W       = 5;
  localparam int CFG_W        = 5;
  localparam int IDLE_ADDRESS = 255;
  localparam int QLEN_RESET   = 10;
  localparam int MAX_DATA_LEN = 6;

  localparam logic [7:0] IDLE_KIND = 8'h10;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_FORGET = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_REPEAT = 2'd1;
  localparam logic [1:0] MODE_EMERG  = 2'd2;

  localparam logic CFG_QUEUE_MODE   = 1'b0;
  localparam logic CFG_QUEUE_LENGTH = 1'b1;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  kind;
    logic [1:0]  akind;
    logic [3:0]  rep;
    logic [2:0]  len;
    logic [47:0] pay;
  } packet_t;

  localparam int PKT_W = $bits(packet_t);

  function automatic packet_t idle_pkt();
    packet_t p;
    p.addr  = 16'(IDLE_ADDRESS);
    p.kind  = IDLE_KIND;
    p.akind = 2'd0;
    p.rep   = 4'd0;
    p.len   = 3'd1;
    p.pay   = 48'd0;
    return p;
  endfunction

endpackage

// ===== rtl/cprq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/coalescing_packet_ring_queue.sv =====
// Top level of the coalescing packet ring queue: sequencer around the slot RAM.
//
// One request at a time; busy is high while a request is worked on. Clear,
// a read of an empty queue and a refused zero-repeat insert in repeat mode
// finish straight from idle; a read waits for the registered RAM data; an
// insert scans the queued packets and stops early when a match is found; a
// repeat-mode read that reinserts then scans the remaining queued packets in
// the same way; a forget scans n slots, n being queue_length held to the
// range 1..16. The scanning pace is set by the slot RAM, which is scanned one
// slot per cycle through its single read port. Each result shows on the
// output ports for exactly one cycle with done high and must be taken then:
// the receiver cannot stall the block. Configuration writes are taken only
// while busy is low; writing queue_length also empties the queue.
module coalescing_packet_ring_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [15:0] address,
  input  logic [7:0]  kind,
  input  logic [1:0]  addr_format,
  input  logic [3:0]  repeat_req,
  input  logic [2:0]  data_len,
  input  logic [47:0] payload,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [cprq_pkg::CFG_W-1:0] cfg_data,
  output logic        done,
  output logic        ok,
  output logic [15:0] out_address,
  output logic [7:0]  out_kind,
  output logic [1:0]  out_addr_format,
  output logic [3:0]  out_repeat,
  output logic [2:0]  out_data_len,
  output logic [47:0] out_payload
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ISCAN  = 4'b0010,
    S_RDDATA = 4'b0100,
    S_FSCAN  = 4'b1000
  } state_t;

  state_t state;

  logic [1:0]                      mode;
  logic [cprq_pkg::QLEN_W-1:0]     qlen;
  logic [cprq_pkg::IDX_W-1:0]      head;
  logic [cprq_pkg::IDX_W-1:0]      tail;
  logic [cprq_pkg::LEN_W-1:0]      fill;
  logic [cprq_pkg::DEPTH-1:0]      vld;
  logic [cprq_pkg::LEN_W-1:0]      issued;
  logic [cprq_pkg::IDX_W-1:0]      scan_idx;
  logic [cprq_pkg::IDX_W-1:0]      cmp_idx;
  logic                            cmp_vld;
  logic                            rd_vld;
  logic                            found;
  logic                            is_read;
  cprq_pkg::packet_t               pkt;
  cprq_pkg::packet_t               res_pkt;
  cprq_pkg::packet_t               out_pkt;

  logic [cprq_pkg::LEN_W-1:0]      nlen;
  cprq_pkg::packet_t               in_pkt;
  cprq_pkg::packet_t               ram_q;
  cprq_pkg::packet_t               rd_pkt;
  cprq_pkg::packet_t               rep_pkt;
  cprq_pkg::packet_t               emg_pkt;
  logic                            ins_hit;
  logic                            fgt_hit;
  logic                            ram_we;
  logic [cprq_pkg::IDX_W-1:0]      ram_waddr;
  cprq_pkg::packet_t               ram_wdata;
  logic [cprq_pkg::IDX_W-1:0]      ram_raddr;

  function automatic logic [cprq_pkg::IDX_W-1:0] idx_inc(
    input logic [cprq_pkg::IDX_W-1:0] i,
    input logic [cprq_pkg::LEN_W-1:0] n
  );
    if (cprq_pkg::LEN_W'(i) + cprq_pkg::LEN_W'(1) == n) begin
      return '0;
    end
    return i + cprq_pkg::IDX_W'(1);
  endfunction

  always_comb begin
    if (qlen == '0) begin
      nlen = cprq_pkg::LEN_W'(1);
    end else if (int'(qlen) > cprq_pkg::DEPTH) begin
      nlen = cprq_pkg::LEN_W'(cprq_pkg::DEPTH);
    end else begin
      nlen = cprq_pkg::LEN_W'(qlen);
    end
  end

  always_comb begin
    in_pkt.addr  = address;
    in_pkt.kind  = kind;
    in_pkt.akind = addr_format;
    in_pkt.rep   = repeat_req;
    in_pkt.len   = (int'(data_len) > cprq_pkg::MAX_DATA_LEN) ?
                   3'(cprq_pkg::MAX_DATA_LEN) : data_len;
    in_pkt.pay   = payload;
  end

  assign rd_pkt  = rd_vld ? ram_q : cprq_pkg::idle_pkt();
  assign ins_hit = cmp_vld && (rd_pkt.addr == pkt.addr) && (rd_pkt.kind == pkt.kind);
  assign fgt_hit = cmp_vld && (rd_pkt.addr == pkt.addr) && (rd_pkt.akind == pkt.akind);

  always_comb begin
    rep_pkt = rd_pkt;
    if (rd_pkt.rep != 4'd0) begin
      rep_pkt.rep = rd_pkt.rep - 4'd1;
    end
    emg_pkt     = rd_pkt;
    emg_pkt.rep = rd_pkt.rep - 4'd1;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmp_idx;
    ram_wdata = pkt;
    ram_raddr = (state == S_IDLE) ? head : scan_idx;
    case (state)
      S_ISCAN: begin
        if (ins_hit) begin
          ram_we = 1'b1;
        end else if (issued == fill && fill < nlen) begin
          ram_we    = 1'b1;
          ram_waddr = tail;
        end
      end
      S_RDDATA: begin
        if (mode == cprq_pkg::MODE_EMERG) begin
          ram_we    = 1'b1;
          ram_waddr = head;
          ram_wdata = emg_pkt;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cprq_ram #(
    .WIDTH (cprq_pkg::PKT_W),
    .DEPTH (cprq_pkg::DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    rd_vld <= vld[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      ok      <= 1'b0;
      mode    <= cprq_pkg::MODE_PLAIN;
      qlen    <= cprq_pkg::QLEN_W'(cprq_pkg::QLEN_RESET);
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      vld     <= '0;
      cmp_vld <= 1'b0;
      found   <= 1'b0;
      is_read <= 1'b0;
      issued  <= '0;
    end else begin
      done <= 1'b0;
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            if (cfg_index == cprq_pkg::CFG_QUEUE_MODE) begin
              mode <= cfg_data[1:0];
            end else begin
              qlen <= cprq_pkg::QLEN_W'(cfg_data);
              vld  <= '0;
              head <= '0;
              tail <= '0;
              fill <= '0;
            end
          end
          if (start) begin
            pkt      <= in_pkt;
            is_read  <= 1'b0;
            issued   <= '0;
            cmp_vld  <= 1'b0;
            found    <= 1'b0;
            scan_idx <= head;
            case (req_type)
              cprq_pkg::REQ_INSERT: begin
                if (mode == cprq_pkg::MODE_REPEAT && repeat_req == 4'd0) begin
                  done    <= 1'b1;
                  ok      <= 1'b0;
                  out_pkt <= '0;
                end else begin
                  state <= S_ISCAN;
                end
              end
              cprq_pkg::REQ_READ: begin
                if (fill == '0) begin
                  done    <= 1'b1;
                  ok      <= 1'b0;
                  out_pkt <= '0;
                end else begin
                  state <= S_RDDATA;
                end
              end
              cprq_pkg::REQ_FORGET: begin
                scan_idx <= '0;
                state    <= S_FSCAN;
              end
              default: begin
                vld     <= '0;
                head    <= '0;
                tail    <= '0;
                fill    <= '0;
                done    <= 1'b1;
                ok      <= 1'b0;
                out_pkt <= '0;
              end
            endcase
          end
        end
        S_ISCAN: begin
          cmp_vld <= 1'b0;
          if (ins_hit) begin
            done    <= 1'b1;
            ok      <= 1'b1;
            out_pkt <= is_read ? res_pkt : '0;
            state   <= S_IDLE;
          end else if (issued == fill) begin
            if (fill < nlen) begin
              tail <= idx_inc(tail, nlen);
              fill <= fill + cprq_pkg::LEN_W'(1);
            end
            done    <= 1'b1;
            ok      <= is_read || (fill < nlen);
            out_pkt <= is_read ? res_pkt : '0;
            state   <= S_IDLE;
          end else begin
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_idx;
            scan_idx <= idx_inc(scan_idx, nlen);
            issued   <= issued + cprq_pkg::LEN_W'(1);
          end
        end
        S_RDDATA: begin
          done  <= 1'b1;
          ok    <= 1'b1;
          state <= S_IDLE;
          case (mode)
            cprq_pkg::MODE_REPEAT: begin
              head <= idx_inc(head, nlen);
              fill <= fill - cprq_pkg::LEN_W'(1);
              if (rep_pkt.rep != 4'd0) begin
                done     <= 1'b0;
                pkt      <= rep_pkt;
                res_pkt  <= rep_pkt;
                is_read  <= 1'b1;
                issued   <= '0;
                cmp_vld  <= 1'b0;
                scan_idx <= idx_inc(head, nlen);
                state    <= S_ISCAN;
              end else begin
                out_pkt <= rep_pkt;
              end
            end
            cprq_pkg::MODE_EMERG: begin
              out_pkt <= emg_pkt;
              if (emg_pkt.rep == 4'd0) begin
                head <= idx_inc(head, nlen);
                fill <= fill - cprq_pkg::LEN_W'(1);
              end
            end
            default: begin
              out_pkt <= rd_pkt;
              head    <= idx_inc(head, nlen);
              fill    <= fill - cprq_pkg::LEN_W'(1);
            end
          endcase
        end
        S_FSCAN: begin
          cmp_vld <= 1'b0;
          if (fgt_hit) begin
            vld[cmp_idx] <= 1'b0;
            found        <= 1'b1;
          end
          if (issued == nlen) begin
            done    <= 1'b1;
            ok      <= found || fgt_hit;
            out_pkt <= '0;
            state   <= S_IDLE;
          end else begin
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_idx;
            scan_idx <= idx_inc(scan_idx, nlen);
            issued   <= issued + cprq_pkg::LEN_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state != S_IDLE);
  assign out_address      = out_pkt.addr;
  assign out_kind         = out_pkt.kind;
  assign out_addr_format  = out_pkt.akind;
  assign out_repeat       = out_pkt.rep;
  assign out_data_len     = out_pkt.len;
  assign out_payload      = out_pkt.pay;

endmodule

// ===== rtl/cprq_checker.sv =====
// Port-level assertions for the coalescing packet ring queue, with its bind.
module cprq_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  req_type,
  input logic        done,
  input logic        ok,
  input logic [15:0] out_address,
  input logic [7:0]  out_kind,
  input logic [1:0]  out_addr_format,
  input logic [3:0]  out_repeat,
  input logic [2:0]  out_data_len,
  input logic [47:0] out_payload
);

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without a transaction in progress");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == cprq_pkg::REQ_CLEAR) |=> (done && !ok))
    else $error("clear did not finish in one cycle with ok low");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (out_address == 16'd0 && out_kind == 8'd0 &&
                       out_addr_format == 2'd0 && out_repeat == 4'd0 &&
                       out_data_len == 3'd0 && out_payload == 48'd0))
    else $error("failed transaction carries packet fields");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_data_len != 3'd7))
    else $error("payload length out of range");

endmodule

bind coalescing_packet_ring_queue cprq_checker u_cprq_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .req_type         (req_type),
  .done             (done),
  .ok               (ok),
  .out_address      (out_address),
  .out_kind         (out_kind),
  .out_addr_format  (out_addr_format),
  .out_repeat       (out_repeat),
  .out_data_len     (out_data_len),
  .out_payload      (out_payload)
);
